>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, muted while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked on every rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> rtl/core/ttc_pkg.sv
// Shared types, constants and helpers for the token time check.
package ttc_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned MINUTES_W   = 20;
   localparam int unsigned WINDOW_W    = 26;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned TEA_ROUNDS  = 32;

   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E3779B9;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_WORD      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_VALID_MINUTES = 2'd1;

   localparam logic [7:0]        HEX_DIGIT_MAX = 8'h39;
   localparam logic [WORD_W-1:0] HEX_ALPHA_OFS = 32'd87;
   localparam logic [WORD_W-1:0] HEX_DIGIT_OFS = 32'd48;

   typedef struct packed {
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] now;
   } tok_type;

   typedef struct packed {
      logic [WORD_W-1:0] decoded_time;
      logic [WORD_W-1:0] now;
   } stamp_type;

   typedef struct packed {
      logic [WORD_W-1:0] decoded_time;
      logic              accepted;
   } verdict_type;

   // Running sum at the start of a round with 'left' rounds remaining.
   function automatic logic [WORD_W-1:0] round_sum(input int unsigned left);
      logic [63:0] prod;
      prod = 64'(TEA_DELTA) * 64'(left);
      return prod[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input int unsigned s);
      return (x << s) | (x >> (WORD_W - s));
   endfunction

endpackage

>>> rtl/core/ttc_req_if.sv
// Request channel: ciphertext block plus current time.
interface ttc_req_if;
   import ttc_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] cipher_word_low;
   logic [WORD_W-1:0] cipher_word_high;
   logic [WORD_W-1:0] now_seconds;

   modport source (output valid, output cipher_word_low, output cipher_word_high,
                   output now_seconds, input ready);
   modport sink   (input valid, input cipher_word_low, input cipher_word_high,
                   input now_seconds, output ready);
endinterface

>>> rtl/core/ttc_rsp_if.sv
// Response channel: decoded time and verdict.
interface ttc_rsp_if;
   import ttc_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] decoded_time;
   logic              accepted;

   modport source (output valid, output decoded_time, output accepted, input ready);
   modport sink   (input valid, input decoded_time, input accepted, output ready);
endinterface

>>> rtl/core/ttc_round_cell.sv
// One TEA decryption round as a pipeline cell.
module ttc_round_cell #(
   parameter logic [31:0] SUM = 32'h0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      key_word,
   input  logic             in_valid,
   output logic             in_ready,
   input  ttc_pkg::tok_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output ttc_pkg::tok_type out_data
);
   import ttc_pkg::*;

   logic              valid_ff, valid_in;
   tok_type           data_ff, data_in;
   logic [WORD_W-1:0] k1, k2, k3;
   logic [WORD_W-1:0] v1_new, v0_new;
   logic              take;

   assign k1 = rotl(key_word, 8);
   assign k2 = rotl(key_word, 16);
   assign k3 = rotl(key_word, 24);

   always_comb begin
      v1_new = in_data.v1 - ((((in_data.v0 << 4) + k2) ^ (in_data.v0 + SUM))
                             ^ ((in_data.v0 >> 5) + k3));
      v0_new = in_data.v0 - ((((v1_new << 4) + key_word) ^ (v1_new + SUM))
                             ^ ((v1_new >> 5) + k1));
   end

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      data_in     = data_ff;
      if (take) begin
         data_in.v0  = v0_new;
         data_in.v1  = v1_new;
         data_in.now = in_data.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

>>> rtl/core/ttc_decode_cell.sv
// Packs the eight plaintext characters into a time value.
module ttc_decode_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ttc_pkg::tok_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ttc_pkg::stamp_type out_data
);
   import ttc_pkg::*;

   logic              valid_ff, valid_in;
   stamp_type         data_ff, data_in;
   logic [WORD_W-1:0] packed_time;
   logic              take;

   // Non-hex bytes keep their full wrapped value and may spill into other nibbles.
   always_comb begin
      logic [63:0]       block;
      logic [7:0]        b;
      logic [WORD_W-1:0] cv;
      block       = {in_data.v1, in_data.v0};
      packed_time = '0;
      for (int i = 0; i < 8; i++) begin
         b  = block[8*i +: 8];
         cv = (b > HEX_DIGIT_MAX) ? (32'(b) - HEX_ALPHA_OFS) : (32'(b) - HEX_DIGIT_OFS);
         packed_time = packed_time | (cv << (28 - 4*i));
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      data_in = data_ff;
      if (take) begin
         data_in.decoded_time = packed_time;
         data_in.now          = in_data.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

>>> rtl/core/ttc_check_cell.sv
// Compares the decoded time with the current time; holds the output beat.
module ttc_check_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ttc_pkg::WINDOW_W-1:0]   window,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  ttc_pkg::stamp_type             in_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output ttc_pkg::verdict_type           out_data
);
   import ttc_pkg::*;

   logic              valid_ff, valid_in;
   verdict_type       data_ff, data_in;
   logic [WORD_W-1:0] gap;
   logic              take;

   // Absolute gap at full width: subtract in the direction that cannot wrap.
   assign gap = (in_data.now >= in_data.decoded_time)
              ? (in_data.now - in_data.decoded_time)
              : (in_data.decoded_time - in_data.now);

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      data_in = data_ff;
      if (take) begin
         data_in.decoded_time = in_data.decoded_time;
         data_in.accepted     = (gap <= WORD_W'(window));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

>>> rtl/core/tea_token_time_check.sv
// Token time check: a ROUNDS-deep chain of TEA round cells, one round per cell,
// followed by a character decode cell and a window compare cell. A new token
// beat is taken every clock cycle while the response side keeps up; each result
// passes through every round cell in turn, then the decode and compare cells.
// Every cell has its own valid bit and moves on whenever its successor has room,
// so a stalled response only stops the cells that are full and bubbles in the
// chain are squeezed out. The key word and window are read live by the cells,
// so write them only while no token is in flight.
module tea_token_time_check #(
   parameter int unsigned ROUNDS = ttc_pkg::TEA_ROUNDS
) (
   input  logic                            clock,
   input  logic                            reset,
   ttc_req_if.sink                         req,
   ttc_rsp_if.source                       rsp,
   input  logic                            csr_write_en,
   input  logic [ttc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ttc_pkg::WORD_W-1:0]      csr_wdata
);
   import ttc_pkg::*;

   logic [WORD_W-1:0]    key_word_ff, key_word_in;
   logic [MINUTES_W-1:0] valid_minutes_ff, valid_minutes_in;
   logic [WINDOW_W-1:0]  window;

   logic      chain_valid [0:ROUNDS];
   logic      chain_ready [0:ROUNDS];
   tok_type   chain_data  [0:ROUNDS];

   logic      dec_valid, dec_ready;
   stamp_type dec_data;
   verdict_type verdict;

   always_comb begin
      key_word_in      = key_word_ff;
      valid_minutes_in = valid_minutes_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_KEY_WORD:      key_word_in      = csr_wdata;
            REG_VALID_MINUTES: valid_minutes_in = csr_wdata[MINUTES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_ff      <= '0;
         valid_minutes_ff <= '0;
      end else begin
         key_word_ff      <= key_word_in;
         valid_minutes_ff <= valid_minutes_in;
      end
   end

   // minutes * 60 = minutes * 64 - minutes * 4
   assign window = {valid_minutes_ff, 6'b0} - WINDOW_W'({valid_minutes_ff, 2'b0});

   assign chain_valid[0]     = req.valid;
   assign req.ready          = chain_ready[0];
   assign chain_data[0].v0   = req.cipher_word_low;
   assign chain_data[0].v1   = req.cipher_word_high;
   assign chain_data[0].now  = req.now_seconds;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      ttc_round_cell #(
         .SUM (round_sum(ROUNDS - r))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .key_word  (key_word_ff),
         .in_valid  (chain_valid[r]),
         .in_ready  (chain_ready[r]),
         .in_data   (chain_data[r]),
         .out_valid (chain_valid[r+1]),
         .out_ready (chain_ready[r+1]),
         .out_data  (chain_data[r+1])
      );
   end

   ttc_decode_cell u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[ROUNDS]),
      .in_ready  (chain_ready[ROUNDS]),
      .in_data   (chain_data[ROUNDS]),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   ttc_check_cell u_check (
      .clock     (clock),
      .reset     (reset),
      .window    (window),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (verdict)
   );

   assign rsp.decoded_time = verdict.decoded_time;
   assign rsp.accepted     = verdict.accepted;
endmodule

>>> rtl/core/ttc_checker.sv
// Port-level checks for the token time check, bound to the top level.
`include "assert_macros.svh"

module ttc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_decoded_time,
   input logic        rsp_accepted
);
   // Input side only backs off when every cell is full and the output is stalled.
   `ASSERT_CLK_RST(a_ready_only_on_stall, clock, reset, !req_ready |-> (rsp_valid && !rsp_ready))
   // Nothing comes out right after reset.
   `ASSERT_CLK(a_quiet_after_reset, clock, $past(reset) |-> !rsp_valid)
   // With the output stage empty every cell can move, so an offered beat is taken.
   `ASSERT_CLK_RST(a_take_when_empty, clock, reset, (req_valid && !rsp_valid) |-> req_ready)
   // Stalled response holds its beat.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_decoded_time) && $stable(rsp_accepted)))
endmodule

bind tea_token_time_check ttc_checker u_ttc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_decoded_time (rsp.decoded_time),
   .rsp_accepted     (rsp.accepted)
);
